// ===== rtl/three_class_priority_queue_macros.svh =====
// Assertion macros for the three-class priority queue.
`ifndef THREE_CLASS_PRIORITY_QUEUE_MACROS_SVH
`define THREE_CLASS_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tcpq_pkg.sv =====
`default_nettype none

package tcpq_pkg;

  localparam int CLASS_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int AGE_BITS    = 7;
  localparam int NUM_CLASSES = 3;
  localparam int CLS_BITS    = 2;
  localparam int CNT_BITS    = $clog2(CLASS_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_BITS-1:0]  id;
    logic [AGE_BITS-1:0] age;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/three_class_priority_queue.sv =====
// A request is captured in the capture step of the controller and carried out in its
// execute step, at the end of which the response is registered as valid. No new request
// is taken while one is executing or while its response waits unaccepted; the all-entry
// id compare and the sorted shift finish in the execute step.
// Reset clears the class counts and the handshake state; store contents are undefined
// until written and are never read beyond a class count, so no clearing pass runs.
`default_nettype none
`include "three_class_priority_queue_macros.svh"

module three_class_priority_queue
  import tcpq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire logic [1:0]          func,
  input  wire logic [ID_BITS-1:0]  entry_id,
  input  wire logic [AGE_BITS-1:0] entry_age,
  input  wire logic [CLS_BITS-1:0] entry_class,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output logic [1:0]               status,
  output logic                     out_valid,
  output logic [ID_BITS-1:0]       out_id,
  output logic [AGE_BITS-1:0]      out_age,
  output logic [CLS_BITS-1:0]      out_class,
  output logic [CNT_BITS-1:0]      top_count,
  output logic [CNT_BITS-1:0]      mid_count,
  output logic [CNT_BITS-1:0]      low_count
);

  cmd_t cmd;

  tcpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .cmd       (cmd)
  );

  tcpq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .entry_id    (entry_id),
    .entry_age   (entry_age),
    .entry_class (entry_class),
    .status      (status),
    .out_valid   (out_valid),
    .out_id      (out_id),
    .out_age     (out_age),
    .out_class   (out_class),
    .top_count   (top_count),
    .mid_count   (mid_count),
    .low_count   (low_count)
  );

  `TCPQ_ASSERT_NEXT(a_rsp_follows_req, cmd.exec, rsp_valid, "response missing after request")
  `TCPQ_ASSERT_NOW(a_fill_bound, 1'b1, (top_count <= CNT_BITS'(CLASS_DEPTH)) && (mid_count <= CNT_BITS'(CLASS_DEPTH)) && (low_count <= CNT_BITS'(CLASS_DEPTH)), "class count exceeds depth")
  `TCPQ_ASSERT_NOW(a_head_ok, rsp_valid && out_valid, status == ST_OK, "head entry with bad status")
  `TCPQ_ASSERT_NOW(a_empty_counts, rsp_valid && (status == ST_EMPTY), (top_count == '0) && (mid_count == '0) && (low_count == '0), "empty status with waiting entries")

endmodule

`default_nettype wire

// ===== rtl/tcpq_ctrl.sv =====
`default_nettype none

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output cmd_t      cmd
);

  typedef enum logic {
    IDLE,
    EXEC
  } state_t;

  state_t state;

  assign req_ready = (state == IDLE) && (!rsp_valid || rsp_ready);
  assign cmd.load  = req_valid && req_ready;
  assign cmd.exec  = (state == EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        IDLE: begin
          if (rsp_ready) begin
            rsp_valid <= 1'b0;
          end
          if (req_valid && req_ready) begin
            state <= EXEC;
          end
        end
        EXEC: begin
          state     <= IDLE;
          rsp_valid <= 1'b1;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tcpq_datapath.sv =====
`default_nettype none

module tcpq_datapath
  import tcpq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cmd_t                cmd,
  input  wire logic [1:0]          func,
  input  wire logic [ID_BITS-1:0]  entry_id,
  input  wire logic [AGE_BITS-1:0] entry_age,
  input  wire logic [CLS_BITS-1:0] entry_class,
  output logic [1:0]               status,
  output logic                     out_valid,
  output logic [ID_BITS-1:0]       out_id,
  output logic [AGE_BITS-1:0]      out_age,
  output logic [CLS_BITS-1:0]      out_class,
  output logic [CNT_BITS-1:0]      top_count,
  output logic [CNT_BITS-1:0]      mid_count,
  output logic [CNT_BITS-1:0]      low_count
);

  func_t               func_q;
  logic [ID_BITS-1:0]  id_q;
  logic [AGE_BITS-1:0] age_q;
  logic [CLS_BITS-1:0] cls_q;

  entry_t              store      [NUM_CLASSES][CLASS_DEPTH];
  entry_t              store_next [NUM_CLASSES][CLASS_DEPTH];
  logic [CNT_BITS-1:0] fill       [NUM_CLASSES];
  logic [CNT_BITS-1:0] fill_next  [NUM_CLASSES];

  logic [NUM_CLASSES-1:0][CLASS_DEPTH-1:0] ge;
  logic                dup;
  logic                head_found;
  logic [CLS_BITS-1:0] head_cls;
  entry_t              head_entry;
  entry_t              new_entry;

  status_t             status_reg;
  status_t             status_next;
  logic                valid_next;
  entry_t              res_next;
  logic [CLS_BITS-1:0] cls_next;

  assign new_entry = '{id: id_q, age: age_q};

  always_comb begin
    dup        = 1'b0;
    head_found = 1'b0;
    head_cls   = '0;
    head_entry = '0;
    ge         = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      for (int i = 0; i < CLASS_DEPTH; i++) begin
        if (CNT_BITS'(i) < fill[c]) begin
          if (store[c][i].id == id_q) begin
            dup = 1'b1;
          end
          ge[c][i] = (store[c][i].age >= age_q);
        end
      end
    end
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fill[c] != '0) begin
        head_found = 1'b1;
        head_cls   = CLS_BITS'(c);
        head_entry = store[c][0];
      end
    end
  end

  always_comb begin
    store_next  = store;
    fill_next   = fill;
    status_next = ST_OK;
    valid_next  = 1'b0;
    res_next    = '0;
    cls_next    = '0;
    case (func_q)
      FUNC_INSERT: begin
        if (dup) begin
          status_next = ST_DUP;
        end else begin
          status_next = ST_FULL;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            if (cls_q == CLS_BITS'(c) && fill[c] < CNT_BITS'(CLASS_DEPTH)) begin
              status_next  = ST_OK;
              fill_next[c] = fill[c] + CNT_BITS'(1);
              if (!ge[c][0]) begin
                store_next[c][0] = new_entry;
              end
              for (int i = 1; i < CLASS_DEPTH; i++) begin
                if (!ge[c][i]) begin
                  store_next[c][i] = ge[c][i-1] ? new_entry : store[c][i-1];
                end
              end
            end
          end
        end
      end
      FUNC_POP, FUNC_PEEK: begin
        if (!head_found) begin
          status_next = ST_EMPTY;
        end else begin
          valid_next = 1'b1;
          res_next   = head_entry;
          cls_next   = head_cls;
          if (func_q == FUNC_POP) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
              if (head_cls == CLS_BITS'(c)) begin
                fill_next[c] = fill[c] - CNT_BITS'(1);
                for (int i = 0; i < CLASS_DEPTH - 1; i++) begin
                  store_next[c][i] = store[c][i+1];
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func_t'(func);
      id_q   <= entry_id;
      age_q  <= entry_age;
      cls_q  <= entry_class;
    end
    if (cmd.exec) begin
      store      <= store_next;
      status_reg <= status_next;
      out_valid  <= valid_next;
      out_id     <= res_next.id;
      out_age    <= res_next.age;
      out_class  <= cls_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        fill[c] <= '0;
      end
    end else if (cmd.exec) begin
      fill <= fill_next;
    end
  end

  assign status    = status_reg;
  assign top_count = fill[0];
  assign mid_count = fill[1];
  assign low_count = fill[2];

endmodule

`default_nettype wire
